// ----- rtl/bbc_pkg.sv -----
// Shared types and constants for the LRU buffer cache tag manager.
package bbc_pkg;

    localparam int DEF_SLOT_COUNT = 16;
    localparam int DEF_REF_MAX    = 255;

    localparam int DEV_W       = 8;
    localparam int SEC_W       = 32;
    localparam int REL_W       = 4;
    localparam int SLOT_OUT_W  = 4;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 8;

    localparam logic MODE_GET     = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_WALK,
        ST_REL_READ,
        ST_REL_LINK,
        ST_REL_FRONT,
        ST_DONE
    } state_t;

    // Result item, laid out as it travels on the result channel.
    typedef struct packed {
        logic                  release_error;
        logic                  no_free_slot;
        logic                  needs_fill;
        logic                  hit;
        logic [SLOT_OUT_W-1:0] slot;
    } res_t;

endpackage

// ----- rtl/block_buffer_cache_refcount_lru_top.sv -----
// LRU buffer cache tag manager with per-slot reference counts.
// Input channel (s_): one request item per handshake. A get looks up a
// device/sector tag; on a hit the slot's count goes up, on a miss the first
// slot in list order with a zero count is retagged and granted. A release
// drops a slot's count and moves the slot to the front of the list when the
// count reaches zero. Result channel (m_): one result item per request.
// A get reads the list head, then visits one list entry at a time, at most
// SLOT_COUNT of them, stopping at a tag match or at the end of the list; each
// step is bound by the registered read of the tag/count memory and the links;
// a release reads the slot, and when the count reaches zero also unlinks it
// and links it in at the front of the list. One request is in flight at a
// time; the next is taken in the cycle after the result is loaded, even
// while it still sits in the output register.
// Reset: all tags zero and not valid, counts zero, list ordered from the
// highest slot down. Per-entry written bits stand in for the memory reset,
// so the block takes requests right after reset.
// A stalled receiver holds the result in the output register; a finished
// request then waits there and the input channel stays not ready.
module block_buffer_cache_refcount_lru_top #(
    parameter int SLOT_COUNT = bbc_pkg::DEF_SLOT_COUNT,
    parameter int REF_MAX    = bbc_pkg::DEF_REF_MAX
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // mode[0], device_id[8:1], sector_number[40:9], release_slot[44:41]
    input  logic [bbc_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // slot[3:0], hit[4], needs_fill[5], no_free_slot[6], release_error[7]
    output logic [bbc_pkg::OUT_TDATA_W-1:0]  m_tdata
);

    localparam int SW = $clog2(SLOT_COUNT);
    localparam int LW = $clog2(SLOT_COUNT + 1);
    localparam int CW = $clog2(REF_MAX + 1);
    localparam int EW = 1 + CW + bbc_pkg::SEC_W + bbc_pkg::DEV_W;
    localparam logic [LW-1:0] ANCHOR  = LW'(SLOT_COUNT);
    localparam logic [CW-1:0] CNT_MAX = CW'(REF_MAX);
    localparam logic [SW-1:0] LAST_STEP = SW'(SLOT_COUNT - 1);

    // Input fields
    logic                            s_mode;
    logic [bbc_pkg::DEV_W-1:0]       s_dev;
    logic [bbc_pkg::SEC_W-1:0]       s_sec;
    logic [bbc_pkg::REL_W-1:0]       s_rel;
    logic                            s_accept;
    logic                            rel_in_range;

    assign s_mode   = s_tdata[0];
    assign s_dev    = s_tdata[8:1];
    assign s_sec    = s_tdata[40:9];
    assign s_rel    = s_tdata[44:41];
    assign s_accept = s_tvalid && s_tready;
    assign rel_in_range = 32'(s_rel) < SLOT_COUNT;

    // Control and payload registers
    bbc_pkg::state_t state_reg, state_next;
    logic [bbc_pkg::DEV_W-1:0] req_dev_reg, req_dev_next;
    logic [bbc_pkg::SEC_W-1:0] req_sec_reg, req_sec_next;
    logic [bbc_pkg::REL_W-1:0] rel_reg, rel_next;
    logic [LW-1:0]             cur_reg, cur_next;
    logic [SW-1:0]             steps_reg, steps_next;
    logic                      have_free_reg, have_free_next;
    logic [SW-1:0]             free_reg, free_next;
    logic [LW-1:0]             lnk_n_reg, lnk_n_next;
    logic [LW-1:0]             lnk_p_reg, lnk_p_next;
    bbc_pkg::res_t             res_reg, res_next;
    bbc_pkg::res_t             m_res_reg, m_res_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic                      m_load;
    logic                      out_free;

    // Memories: tag/count/valid per slot, and next/prev link banks
    logic [EW-1:0]   slot_mem [SLOT_COUNT];
    logic [LW-1:0]   next_mem [SLOT_COUNT+1];
    logic [LW-1:0]   prev_mem [SLOT_COUNT+1];
    logic [SLOT_COUNT-1:0] slot_init_reg;
    logic [SLOT_COUNT:0]   next_init_reg;
    logic [SLOT_COUNT:0]   prev_init_reg;

    logic [LW-1:0] rd_addr;
    logic [SW-1:0] slot_rd_idx;
    logic [LW-1:0] rd_addr_q_reg;
    logic [EW-1:0] slot_rd_reg;
    logic [LW-1:0] next_rd_reg;
    logic [LW-1:0] prev_rd_reg;
    logic          slot_rd_init_reg;
    logic          next_rd_init_reg;
    logic          prev_rd_init_reg;

    logic          slot_we;
    logic [SW-1:0] slot_wa;
    logic [EW-1:0] slot_wd;
    logic          next_we;
    logic [LW-1:0] next_wa;
    logic [LW-1:0] next_wd;
    logic          prev_we;
    logic [LW-1:0] prev_wa;
    logic [LW-1:0] prev_wd;

    // Effective read data: an entry never written reads as its reset value
    logic [EW-1:0]             slot_rd;
    logic [bbc_pkg::DEV_W-1:0] rd_dev;
    logic [bbc_pkg::SEC_W-1:0] rd_sec;
    logic [CW-1:0]             rd_cnt;
    logic                      rd_valid;
    logic [LW-1:0]             next_rd;
    logic [LW-1:0]             prev_rd;

    assign slot_rd  = slot_rd_init_reg ? slot_rd_reg : '0;
    assign rd_dev   = slot_rd[bbc_pkg::DEV_W-1:0];
    assign rd_sec   = slot_rd[bbc_pkg::DEV_W +: bbc_pkg::SEC_W];
    assign rd_cnt   = slot_rd[bbc_pkg::DEV_W + bbc_pkg::SEC_W +: CW];
    assign rd_valid = slot_rd[EW-1];
    assign next_rd  = next_rd_init_reg ? next_rd_reg :
                      ((rd_addr_q_reg == '0) ? ANCHOR : LW'(rd_addr_q_reg - 1'b1));
    assign prev_rd  = prev_rd_init_reg ? prev_rd_reg :
                      ((rd_addr_q_reg == ANCHOR) ? '0 : LW'(rd_addr_q_reg + 1'b1));

    assign slot_rd_idx = (rd_addr < ANCHOR) ? rd_addr[SW-1:0] : '0;

    // Walk decisions
    logic          tag_match;
    logic          walk_end;
    logic          claim_ok;
    logic [SW-1:0] claim_slot;
    logic [CW-1:0] cnt_inc;
    logic [LW-1:0] rel_idx;
    logic [LW-1:0] front_first;

    assign tag_match  = (rd_dev == req_dev_reg) && (rd_sec == req_sec_reg);
    assign walk_end   = (steps_reg == LAST_STEP) || (next_rd >= ANCHOR);
    assign claim_ok   = have_free_reg || (rd_cnt == '0);
    assign claim_slot = have_free_reg ? free_reg : cur_reg[SW-1:0];
    assign cnt_inc    = (rd_cnt == CNT_MAX) ? rd_cnt : CW'(rd_cnt + 1'b1);
    assign rel_idx    = LW'(rel_reg);
    // Unlink may have just rewritten the anchor's next link: forward it
    assign front_first = (lnk_p_reg == ANCHOR) ? lnk_n_reg : next_rd;

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            bbc_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (s_mode == bbc_pkg::MODE_GET) begin
                        state_next = bbc_pkg::ST_HEAD;
                    end else if (rel_in_range) begin
                        state_next = bbc_pkg::ST_REL_READ;
                    end else begin
                        state_next = bbc_pkg::ST_DONE;
                    end
                end
            end
            bbc_pkg::ST_HEAD: begin
                state_next = (next_rd < ANCHOR) ? bbc_pkg::ST_WALK : bbc_pkg::ST_DONE;
            end
            bbc_pkg::ST_WALK: begin
                if (tag_match || walk_end) begin
                    state_next = bbc_pkg::ST_DONE;
                end
            end
            bbc_pkg::ST_REL_READ: begin
                state_next = (rd_cnt == CW'(1)) ? bbc_pkg::ST_REL_LINK : bbc_pkg::ST_DONE;
            end
            bbc_pkg::ST_REL_LINK:  state_next = bbc_pkg::ST_REL_FRONT;
            bbc_pkg::ST_REL_FRONT: state_next = bbc_pkg::ST_DONE;
            bbc_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = bbc_pkg::ST_IDLE;
                end
            end
            default: state_next = bbc_pkg::ST_IDLE;
        endcase
    end

    // Outputs, memory controls and datapath
    always_comb begin
        s_tready       = 1'b0;
        m_load         = 1'b0;
        rd_addr        = cur_reg;
        slot_we        = 1'b0;
        slot_wa        = SW'(rel_reg);
        slot_wd        = slot_rd;
        next_we        = 1'b0;
        next_wa        = rel_idx;
        next_wd        = '0;
        prev_we        = 1'b0;
        prev_wa        = rel_idx;
        prev_wd        = '0;
        req_dev_next   = req_dev_reg;
        req_sec_next   = req_sec_reg;
        rel_next       = rel_reg;
        cur_next       = cur_reg;
        steps_next     = steps_reg;
        have_free_next = have_free_reg;
        free_next      = free_reg;
        lnk_n_next     = lnk_n_reg;
        lnk_p_next     = lnk_p_reg;
        res_next       = res_reg;
        case (state_reg)
            bbc_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                rd_addr  = (s_mode == bbc_pkg::MODE_GET) ? ANCHOR : LW'(s_rel);
                if (s_accept) begin
                    req_dev_next   = s_dev;
                    req_sec_next   = s_sec;
                    rel_next       = s_rel;
                    steps_next     = '0;
                    have_free_next = 1'b0;
                    res_next       = '0;
                    if (s_mode == bbc_pkg::MODE_RELEASE) begin
                        res_next.slot          = s_rel;
                        res_next.release_error = !rel_in_range;
                    end
                end
            end
            bbc_pkg::ST_HEAD: begin
                rd_addr  = next_rd;
                cur_next = next_rd;
                if (next_rd >= ANCHOR) begin
                    res_next.no_free_slot = 1'b1;
                end
            end
            bbc_pkg::ST_WALK: begin
                rd_addr    = next_rd;
                cur_next   = next_rd;
                steps_next = SW'(steps_reg + 1'b1);
                if (!have_free_reg && rd_cnt == '0) begin
                    have_free_next = 1'b1;
                    free_next      = cur_reg[SW-1:0];
                end
                if (tag_match) begin
                    slot_we             = 1'b1;
                    slot_wa             = cur_reg[SW-1:0];
                    slot_wd             = {1'b1, cnt_inc, rd_sec, rd_dev};
                    res_next.slot       = bbc_pkg::SLOT_OUT_W'(cur_reg);
                    res_next.hit        = 1'b1;
                    res_next.needs_fill = !rd_valid;
                end else if (walk_end) begin
                    if (claim_ok) begin
                        slot_we             = 1'b1;
                        slot_wa             = claim_slot;
                        slot_wd             = {1'b1, CW'(1), req_sec_reg, req_dev_reg};
                        res_next.slot       = bbc_pkg::SLOT_OUT_W'(claim_slot);
                        res_next.needs_fill = 1'b1;
                    end else begin
                        res_next.no_free_slot = 1'b1;
                    end
                end
            end
            bbc_pkg::ST_REL_READ: begin
                rd_addr    = ANCHOR;
                lnk_n_next = next_rd;
                lnk_p_next = prev_rd;
                if (rd_cnt == '0) begin
                    res_next.release_error = 1'b1;
                end else begin
                    slot_we = 1'b1;
                    slot_wa = SW'(rel_reg);
                    slot_wd = {rd_valid, CW'(rd_cnt - 1'b1), rd_sec, rd_dev};
                    if (rd_cnt == CW'(1)) begin
                        // unlink: next[prev] = next, prev[next] = prev
                        next_we = 1'b1;
                        next_wa = prev_rd;
                        next_wd = next_rd;
                        prev_we = 1'b1;
                        prev_wa = next_rd;
                        prev_wd = prev_rd;
                    end
                end
            end
            bbc_pkg::ST_REL_LINK: begin
                next_we = 1'b1;
                next_wa = rel_idx;
                next_wd = front_first;
                prev_we = 1'b1;
                prev_wa = front_first;
                prev_wd = rel_idx;
            end
            bbc_pkg::ST_REL_FRONT: begin
                next_we = 1'b1;
                next_wa = ANCHOR;
                next_wd = rel_idx;
                prev_we = 1'b1;
                prev_wa = rel_idx;
                prev_wd = ANCHOR;
            end
            bbc_pkg::ST_DONE: begin
                m_load = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign m_res_next    = m_load ? res_reg : m_res_reg;
    assign m_tvalid_next = m_load ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_res_reg;

    // Memory arrays with registered reads
    always_ff @(posedge aclk) begin
        if (slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        if (next_we) begin
            next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            prev_mem[prev_wa] <= prev_wd;
        end
        slot_rd_reg   <= slot_mem[slot_rd_idx];
        next_rd_reg   <= next_mem[rd_addr];
        prev_rd_reg   <= prev_mem[rd_addr];
        rd_addr_q_reg <= rd_addr;
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_dev_reg   <= req_dev_next;
        req_sec_reg   <= req_sec_next;
        rel_reg       <= rel_next;
        cur_reg       <= cur_next;
        steps_reg     <= steps_next;
        have_free_reg <= have_free_next;
        free_reg      <= free_next;
        lnk_n_reg     <= lnk_n_next;
        lnk_p_reg     <= lnk_p_next;
        res_reg       <= res_next;
        m_res_reg     <= m_res_next;
    end

    // Control registers and written bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= bbc_pkg::ST_IDLE;
            m_tvalid_reg     <= 1'b0;
            slot_init_reg    <= '0;
            next_init_reg    <= '0;
            prev_init_reg    <= '0;
            slot_rd_init_reg <= 1'b0;
            next_rd_init_reg <= 1'b0;
            prev_rd_init_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (slot_we) begin
                slot_init_reg[slot_wa] <= 1'b1;
            end
            if (next_we) begin
                next_init_reg[next_wa] <= 1'b1;
            end
            if (prev_we) begin
                prev_init_reg[prev_wa] <= 1'b1;
            end
            slot_rd_init_reg <= slot_init_reg[slot_rd_idx];
            next_rd_init_reg <= next_init_reg[rd_addr];
            prev_rd_init_reg <= prev_init_reg[rd_addr];
        end
    end

`ifndef SYNTHESIS
    a_hit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_res_reg.hit |-> !m_res_reg.no_free_slot && !m_res_reg.release_error)
        else $error("hit result carries an error flag");

    a_nofree_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_res_reg.no_free_slot |-> m_res_reg.slot == '0 && !m_res_reg.needs_fill)
        else $error("no-free result carries a slot");

    a_walk_cur: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bbc_pkg::ST_WALK |-> cur_reg < ANCHOR)
        else $error("walk left the slot range");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg != bbc_pkg::ST_IDLE)
        else $error("accepted item did not start work");

    a_front_after_link: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == bbc_pkg::ST_REL_FRONT |-> $past(state_reg) == bbc_pkg::ST_REL_LINK)
        else $error("push to front without unlink");
`endif

endmodule
